### rtl/chc_pkg.sv
// Shared types and constants for the compass heading calibrator.
// No dependencies; the files that use it refer to this package by scoped names.
package chc_pkg;

    // angle scale: 1/64 degree
    localparam int unsigned ANGLE_FRAC_BITS = 6;
    localparam logic [14:0] FULL_TURN = 15'(360 << ANGLE_FRAC_BITS);
    localparam logic [14:0] HALF_TURN = 15'(180 << ANGLE_FRAC_BITS);

    // CORDIC datapath width, progress divider length and atan table length
    localparam int unsigned CORDIC_W  = 37;
    localparam int unsigned DIV_STEPS = 8;
    localparam int unsigned ATAN_ENTRIES = 24;

    // command codes
    localparam logic [1:0] CMD_SAMPLE = 2'd0;
    localparam logic [1:0] CMD_START  = 2'd1;
    localparam logic [1:0] CMD_STOP   = 2'd2;
    localparam logic [1:0] CMD_LOAD   = 2'd3;

    // stop status codes
    localparam logic [1:0] STOP_NONE    = 2'd0;
    localparam logic [1:0] STOP_APPLIED = 2'd1;
    localparam logic [1:0] STOP_CANCEL  = 2'd2;

    // configuration register indexes
    localparam logic [2:0] CFG_DECLINATION = 3'd0;
    localparam logic [2:0] CFG_SNAP        = 3'd1;
    localparam logic [2:0] CFG_MIN_SAMPLES = 3'd2;
    localparam logic [2:0] CFG_GOOD_SPREAD = 3'd3;
    localparam logic [2:0] CFG_TARGET      = 3'd4;
    localparam logic [2:0] CFG_SKIP        = 3'd5;

    // configuration reset values
    localparam logic [14:0] DECL_RST   = 15'd2496;
    localparam logic [13:0] SNAP_RST   = 14'd1920;
    localparam logic [9:0]  MINS_RST   = 10'd50;
    localparam logic [15:0] GOOD_RST   = 16'd3500;
    localparam logic [15:0] TARGET_RST = 16'd5000;
    localparam logic [7:0]  SKIP_RST   = 8'd5;

    // commands from the controller to the datapath
    typedef struct packed {
        logic accept;
        logic mul;
        logic pre;
        logic iter;
        logic rnd;
        logic hdg;
        logic ema;
        logic div;
        logic load_out;
    } cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        logic proc_sample;
    } stat_t;

    // result payload
    typedef struct packed {
        logic [14:0] heading;
        logic        heading_valid;
        logic        cal_active;
        logic [15:0] cal_count;
        logic [8:0]  cal_progress;
        logic        cal_good;
        logic [1:0]  stop_status;
    } res_t;

    // atan(2^-i) as a fraction of a full turn times 2^32
    function automatic logic [31:0] atan_entry(input logic [4:0] i);
        logic [31:0] v;
        case (i)
            5'd0:    v = 32'h20000000;
            5'd1:    v = 32'h12E4051E;
            5'd2:    v = 32'h09FB385B;
            5'd3:    v = 32'h051111D4;
            5'd4:    v = 32'h028B0D43;
            5'd5:    v = 32'h0145D7E1;
            5'd6:    v = 32'h00A2F61E;
            5'd7:    v = 32'h00517C55;
            5'd8:    v = 32'h0028BE53;
            5'd9:    v = 32'h00145F2F;
            5'd10:   v = 32'h000A2F98;
            5'd11:   v = 32'h000517CC;
            5'd12:   v = 32'h00028BE6;
            5'd13:   v = 32'h000145F3;
            5'd14:   v = 32'h0000A2FA;
            5'd15:   v = 32'h0000517D;
            5'd16:   v = 32'h000028BE;
            5'd17:   v = 32'h0000145F;
            5'd18:   v = 32'h00000A30;
            5'd19:   v = 32'h00000518;
            5'd20:   v = 32'h0000028C;
            5'd21:   v = 32'h00000146;
            5'd22:   v = 32'h000000A3;
            5'd23:   v = 32'h00000051;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

endpackage

### rtl/chc_in_if.sv
// Input channel of the compass heading calibrator: handshake and command payload.
// Depends on nothing.
interface chc_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         command;
    logic signed [15:0] raw_x;
    logic signed [15:0] raw_y;
    logic               fresh;
    logic signed [15:0] load_offset_x;
    logic signed [15:0] load_offset_y;
    logic [15:0]        load_scale_x;
    logic [15:0]        load_scale_y;

    modport source (
        output valid, command, raw_x, raw_y, fresh,
               load_offset_x, load_offset_y, load_scale_x, load_scale_y,
        input  ready
    );
    modport sink (
        input  valid, command, raw_x, raw_y, fresh,
               load_offset_x, load_offset_y, load_scale_x, load_scale_y,
        output ready
    );
endinterface

### rtl/chc_out_if.sv
// Result channel of the compass heading calibrator: handshake and status payload.
// Depends on nothing.
interface chc_out_if;
    logic        valid;
    logic        ready;
    logic [14:0] heading;
    logic        heading_valid;
    logic        cal_active;
    logic [15:0] cal_count;
    logic [8:0]  cal_progress;
    logic        cal_good;
    logic [1:0]  stop_status;

    modport source (
        output valid, heading, heading_valid, cal_active, cal_count,
               cal_progress, cal_good, stop_status,
        input  ready
    );
    modport sink (
        input  valid, heading, heading_valid, cal_active, cal_count,
               cal_progress, cal_good, stop_status,
        output ready
    );
endinterface

### rtl/chc_ctrl.sv
// Sequencer of the compass heading calibrator: accepts a beat, steps the datapath.
// Depends on chc_pkg (cmd_t, stat_t, DIV_STEPS).
module chc_ctrl #(
    parameter int unsigned CORDIC_ITERATIONS = 16,
    parameter int unsigned IW = $clog2(CORDIC_ITERATIONS)
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    input  chc_pkg::stat_t       stat,
    output chc_pkg::cmd_t        cmd,
    output logic [IW-1:0]        step
);

    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001,
        S_MUL  = 9'b000000010,
        S_PRE  = 9'b000000100,
        S_ITER = 9'b000001000,
        S_RND  = 9'b000010000,
        S_HDG  = 9'b000100000,
        S_EMA  = 9'b001000000,
        S_DIV  = 9'b010000000,
        S_DONE = 9'b100000000
    } state_t;

    state_t        state_reg, state_next;
    logic [IW-1:0] step_reg, step_next;
    logic          out_valid_reg, out_valid_next;
    logic          iter_last, div_last;

    assign iter_last = (step_reg == IW'(CORDIC_ITERATIONS - 1));
    assign div_last  = (step_reg == IW'(chc_pkg::DIV_STEPS - 1));

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign step      = step_reg;

    // advance the sequence and issue datapath commands
    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    step_next  = '0;
                    state_next = stat.proc_sample ? S_MUL : S_DIV;
                end
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_PRE;
            end
            S_PRE:
            begin
                cmd.pre    = 1'b1;
                step_next  = '0;
                state_next = S_ITER;
            end
            S_ITER:
            begin
                cmd.iter = 1'b1;
                if (iter_last)
                begin
                    step_next  = '0;
                    state_next = S_RND;
                end
                else
                begin
                    step_next = step_reg + 1'b1;
                end
            end
            S_RND:
            begin
                cmd.rnd    = 1'b1;
                state_next = S_HDG;
            end
            S_HDG:
            begin
                cmd.hdg    = 1'b1;
                state_next = S_EMA;
            end
            S_EMA:
            begin
                cmd.ema    = 1'b1;
                step_next  = '0;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                cmd.div = 1'b1;
                if (div_last)
                begin
                    step_next  = '0;
                    state_next = S_DONE;
                end
                else
                begin
                    step_next = step_reg + 1'b1;
                end
            end
            S_DONE:
            begin
                // hold until the result register is free
                if (!out_valid_reg || out_ready)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

### rtl/chc_datapath.sv
// Datapath of the compass heading calibrator: calibration state, CORDIC, smoother,
// progress divider and result register. Depends on chc_pkg.
module chc_datapath #(
    parameter int unsigned CORDIC_ITERATIONS = 16,
    parameter int unsigned IW = $clog2(CORDIC_ITERATIONS)
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [15:0]        cfg_data,
    input  logic [1:0]         command,
    input  logic signed [15:0] raw_x,
    input  logic signed [15:0] raw_y,
    input  logic               fresh,
    input  logic signed [15:0] load_offset_x,
    input  logic signed [15:0] load_offset_y,
    input  logic [15:0]        load_scale_x,
    input  logic [15:0]        load_scale_y,
    input  chc_pkg::cmd_t      cmd,
    input  logic [IW-1:0]      step,
    output chc_pkg::stat_t     stat,
    output chc_pkg::res_t      res
);

    localparam int unsigned CW = chc_pkg::CORDIC_W;

    // configuration
    logic [14:0] decl_reg;
    logic [13:0] snap_reg;
    logic [9:0]  mins_reg;
    logic [15:0] good_reg, tgt_reg;
    logic [7:0]  skip_reg;

    // calibration and smoother state
    logic [14:0]        ema_reg, ema_next;
    logic               ema_valid_reg, ema_valid_next;
    logic               run_reg, run_next;
    logic [15:0]        samples_reg, samples_next;
    logic signed [15:0] minx_reg, minx_next, maxx_reg, maxx_next;
    logic signed [15:0] miny_reg, miny_next, maxy_reg, maxy_next;
    logic signed [15:0] offx_reg, offx_next, offy_reg, offy_next;
    logic [15:0]        sclx_reg, sclx_next, scly_reg, scly_next;
    logic [1:0]         stop_reg, stop_next;

    // per-sample working registers
    logic signed [15:0]   rx_reg, ry_reg;
    logic signed [CW-1:0] cx_reg, cx_next, cy_reg, cy_next;
    logic [31:0]          cz_reg, cz_next;
    logic                 zero_reg, zero_next;
    logic [15:0]          ang_reg;
    logic [14:0]          hdg_reg;
    logic [15:0]          rem_reg, rem_next;
    logic [7:0]           quot_reg, quot_next;
    chc_pkg::res_t        res_reg;

    // derived values
    logic signed [16:0] sprx, spry, weak_spr, sumx, sumy;
    logic signed [16:0] dx, ndy;
    logic signed [33:0] px, py;
    logic [15:0]        tgt_eff;
    logic               eligible;

    assign sprx     = 17'(maxx_reg) - 17'(minx_reg);
    assign spry     = 17'(maxy_reg) - 17'(miny_reg);
    assign weak_spr = (sprx < spry) ? sprx : spry;
    assign sumx     = 17'(minx_reg) + 17'(maxx_reg);
    assign sumy     = 17'(miny_reg) + 17'(maxy_reg);
    assign tgt_eff  = (tgt_reg == 16'd0) ? 16'd1 : tgt_reg;
    assign eligible = run_reg && (samples_reg > {8'd0, skip_reg}) && (weak_spr > 17'sd0);

    assign stat.proc_sample = (command == chc_pkg::CMD_SAMPLE) &&
                              (run_reg || fresh || !ema_valid_reg);

    // corrected axes, cross-multiplied by the other axis scale
    assign dx  = 17'(rx_reg) - 17'(offx_reg);
    assign ndy = 17'(offy_reg) - 17'(ry_reg);
    assign px  = ndy * $signed({1'b0, sclx_reg});
    assign py  = dx * $signed({1'b0, scly_reg});

    assign res = res_reg;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            decl_reg <= chc_pkg::DECL_RST;
            snap_reg <= chc_pkg::SNAP_RST;
            mins_reg <= chc_pkg::MINS_RST;
            good_reg <= chc_pkg::GOOD_RST;
            tgt_reg  <= chc_pkg::TARGET_RST;
            skip_reg <= chc_pkg::SKIP_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                chc_pkg::CFG_DECLINATION: decl_reg <= cfg_data[14:0];
                chc_pkg::CFG_SNAP:        snap_reg <= cfg_data[13:0];
                chc_pkg::CFG_MIN_SAMPLES: mins_reg <= cfg_data[9:0];
                chc_pkg::CFG_GOOD_SPREAD: good_reg <= cfg_data;
                chc_pkg::CFG_TARGET:      tgt_reg  <= cfg_data;
                chc_pkg::CFG_SKIP:        skip_reg <= cfg_data[7:0];
                default:                  ;
            endcase
        end
    end

    // command handling on the accepted beat and smoother update
    always_comb
    begin
        logic [15:0]        cnt;
        logic signed [16:0] hx, hy;
        logic signed [17:0] diff, e;
        logic signed [17:0] mag;
        ema_next       = ema_reg;
        ema_valid_next = ema_valid_reg;
        run_next       = run_reg;
        samples_next   = samples_reg;
        minx_next      = minx_reg;
        maxx_next      = maxx_reg;
        miny_next      = miny_reg;
        maxy_next      = maxy_reg;
        offx_next      = offx_reg;
        offy_next      = offy_reg;
        sclx_next      = sclx_reg;
        scly_next      = scly_reg;
        stop_next      = stop_reg;
        cnt            = (samples_reg == 16'hFFFF) ? samples_reg : samples_reg + 16'd1;
        hx             = (sumx + 17'(sumx[16])) >>> 1;
        hy             = (sumy + 17'(sumy[16])) >>> 1;
        diff           = 18'(signed'({3'b0, hdg_reg})) - 18'(signed'({3'b0, ema_reg}));
        if (diff > 18'(signed'({3'b0, chc_pkg::HALF_TURN})))
        begin
            diff = diff - 18'(signed'({3'b0, chc_pkg::FULL_TURN}));
        end
        if (diff < -18'(signed'({3'b0, chc_pkg::HALF_TURN})))
        begin
            diff = diff + 18'(signed'({3'b0, chc_pkg::FULL_TURN}));
        end
        mag = (diff < 18'sd0) ? -diff : diff;
        e   = 18'(signed'({3'b0, ema_reg})) + (diff >>> 1);
        if (e < 18'sd0)
        begin
            e = e + 18'(signed'({3'b0, chc_pkg::FULL_TURN}));
        end
        if (e >= 18'(signed'({3'b0, chc_pkg::FULL_TURN})))
        begin
            e = e - 18'(signed'({3'b0, chc_pkg::FULL_TURN}));
        end

        if (cmd.accept)
        begin
            stop_next = chc_pkg::STOP_NONE;
            case (command)
                chc_pkg::CMD_SAMPLE:
                begin
                    if (stat.proc_sample && run_reg)
                    begin
                        samples_next = cnt;
                        if (cnt > {8'd0, skip_reg})
                        begin
                            if (raw_x < minx_reg) minx_next = raw_x;
                            if (raw_x > maxx_reg) maxx_next = raw_x;
                            if (raw_y < miny_reg) miny_next = raw_y;
                            if (raw_y > maxy_reg) maxy_next = raw_y;
                        end
                    end
                end
                chc_pkg::CMD_START:
                begin
                    minx_next      = 16'sh7FFF;
                    maxx_next      = -16'sh8000;
                    miny_next      = 16'sh7FFF;
                    maxy_next      = -16'sh8000;
                    samples_next   = '0;
                    run_next       = 1'b1;
                    ema_valid_next = 1'b0;
                end
                chc_pkg::CMD_STOP:
                begin
                    run_next = 1'b0;
                    if (samples_reg < {6'd0, mins_reg})
                    begin
                        stop_next = chc_pkg::STOP_CANCEL;
                    end
                    else
                    begin
                        offx_next      = hx[15:0];
                        offy_next      = hy[15:0];
                        sclx_next      = (sprx > 17'sd1) ? sprx[15:0] : 16'd2;
                        scly_next      = (spry > 17'sd1) ? spry[15:0] : 16'd2;
                        ema_valid_next = 1'b0;
                        stop_next      = chc_pkg::STOP_APPLIED;
                    end
                end
                chc_pkg::CMD_LOAD:
                begin
                    offx_next      = load_offset_x;
                    offy_next      = load_offset_y;
                    sclx_next      = (load_scale_x == 16'd0) ? 16'd2 : load_scale_x;
                    scly_next      = (load_scale_y == 16'd0) ? 16'd2 : load_scale_y;
                    ema_valid_next = 1'b0;
                end
                default:
                begin
                    stop_next = chc_pkg::STOP_NONE;
                end
            endcase
        end

        // smooth, or snap on a large change or while the smoother holds no heading
        if (cmd.ema)
        begin
            ema_valid_next = 1'b1;
            if (!ema_valid_reg || (mag > 18'(signed'({4'b0, snap_reg}))))
            begin
                ema_next = hdg_reg;
            end
            else
            begin
                ema_next = e[14:0];
            end
        end
    end

    // CORDIC vectoring and progress division
    always_comb
    begin
        logic signed [CW-1:0] xs, ys;
        logic [31:0]          at;
        logic [15:0]          cur;
        logic [16:0]          sh;
        logic [7:0]           qbase;
        cx_next   = cx_reg;
        cy_next   = cy_reg;
        cz_next   = cz_reg;
        zero_next = zero_reg;
        rem_next  = rem_reg;
        quot_next = quot_reg;
        xs        = cx_reg >>> step;
        ys        = cy_reg >>> step;
        at        = chc_pkg::atan_entry(5'(step));
        cur       = (step == '0) ? weak_spr[15:0] : rem_reg;
        sh        = {cur, 1'b0};
        qbase     = (step == '0) ? 8'd0 : quot_reg;

        if (cmd.mul)
        begin
            cx_next = CW'(px);
            cy_next = CW'(py);
        end
        // fold the left half plane and flag the zero vector
        if (cmd.pre)
        begin
            zero_next = (cx_reg == '0) && (cy_reg == '0);
            if (cx_reg < 0)
            begin
                cx_next = -cx_reg;
                cy_next = -cy_reg;
                cz_next = 32'h8000_0000;
            end
            else
            begin
                cz_next = 32'h0;
            end
        end
        if (cmd.iter)
        begin
            if (cy_reg > 0)
            begin
                cx_next = cx_reg + ys;
                cy_next = cy_reg - xs;
                cz_next = cz_reg + at;
            end
            else
            begin
                cx_next = cx_reg - ys;
                cy_next = cy_reg + xs;
                cz_next = cz_reg - at;
            end
        end
        // one restoring step of weak_spr*256/target
        if (cmd.div)
        begin
            if (sh >= {1'b0, tgt_eff})
            begin
                rem_next  = 16'(sh - {1'b0, tgt_eff});
                quot_next = {qbase[6:0], 1'b1};
            end
            else
            begin
                rem_next  = sh[15:0];
                quot_next = {qbase[6:0], 1'b0};
            end
        end
    end

    // rounding to 1/64 degree and declination
    logic [47:0] rnd_prod;
    logic [15:0] ang_w;
    logic [14:0] dec_w;
    logic [16:0] h_sum;

    assign rnd_prod = {16'd0, (zero_reg ? 32'd0 : cz_reg)} * {33'd0, chc_pkg::FULL_TURN}
                      + 48'h0000_8000_0000;
    assign ang_w = (ang_reg >= {1'b0, chc_pkg::FULL_TURN}) ?
                   ang_reg - {1'b0, chc_pkg::FULL_TURN} : ang_reg;
    assign dec_w = (decl_reg >= chc_pkg::FULL_TURN) ? decl_reg - chc_pkg::FULL_TURN : decl_reg;
    assign h_sum = {1'b0, ang_w} + {2'b0, chc_pkg::FULL_TURN} - {2'b0, dec_w};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ema_reg       <= '0;
            ema_valid_reg <= 1'b0;
            run_reg       <= 1'b0;
            samples_reg   <= '0;
            minx_reg      <= '0;
            maxx_reg      <= '0;
            miny_reg      <= '0;
            maxy_reg      <= '0;
            offx_reg      <= '0;
            offy_reg      <= '0;
            sclx_reg      <= 16'd2;
            scly_reg      <= 16'd2;
            stop_reg      <= chc_pkg::STOP_NONE;
        end
        else
        begin
            ema_reg       <= ema_next;
            ema_valid_reg <= ema_valid_next;
            run_reg       <= run_next;
            samples_reg   <= samples_next;
            minx_reg      <= minx_next;
            maxx_reg      <= maxx_next;
            miny_reg      <= miny_next;
            maxy_reg      <= maxy_next;
            offx_reg      <= offx_next;
            offy_reg      <= offy_next;
            sclx_reg      <= sclx_next;
            scly_reg      <= scly_next;
            stop_reg      <= stop_next;
        end
    end

    // working registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            rx_reg <= raw_x;
            ry_reg <= raw_y;
        end
        cx_reg   <= cx_next;
        cy_reg   <= cy_next;
        cz_reg   <= cz_next;
        zero_reg <= zero_next;
        rem_reg  <= rem_next;
        quot_reg <= quot_next;
        if (cmd.rnd)
        begin
            ang_reg <= rnd_prod[47:32];
        end
        if (cmd.hdg)
        begin
            hdg_reg <= (h_sum >= {2'b0, chc_pkg::FULL_TURN}) ?
                       15'(h_sum - {2'b0, chc_pkg::FULL_TURN}) : h_sum[14:0];
        end
        if (cmd.load_out)
        begin
            res_reg.heading       <= ema_valid_reg ? ema_reg : 15'd0;
            res_reg.heading_valid <= ema_valid_reg;
            res_reg.cal_active    <= run_reg;
            res_reg.cal_count     <= samples_reg;
            res_reg.cal_progress  <= !eligible ? 9'd0 :
                                     (weak_spr >= 17'(signed'({1'b0, tgt_eff}))) ? 9'd256 :
                                     {1'b0, quot_reg};
            res_reg.cal_good      <= (samples_reg >= {6'd0, mins_reg}) &&
                                     (weak_spr >= 17'(signed'({1'b0, good_reg})));
            res_reg.stop_status   <= stop_reg;
        end
    end

endmodule

### rtl/compass_heading_calibrator_top.sv
// Top level of the compass heading calibrator: controller, datapath and channel wiring.
// Depends on chc_pkg, chc_in_if, chc_out_if, chc_ctrl and chc_datapath.
//
//  channel     dir  payload
//  sample_in   in   command, raw_x, raw_y, fresh, load offsets and scales
//  result_out  out  heading, heading_valid, cal_active, cal_count, cal_progress,
//                   cal_good, stop_status
//  cfg_*       in   write enable, 3-bit index, 16-bit data
//
// A processed sample steps through MUL, PRE, the one-step-per-cycle CORDIC loop,
// RND, HDG, EMA, the 8-step progress divider and DONE. Other commands and stale
// samples go from accept to the progress divider and DONE. One item is in work at a time.
// The result register holds its beat until taken; a new item is accepted meanwhile.
// Reset is asynchronous and active low; no clearing pass is needed.
module compass_heading_calibrator_top #(
    parameter int unsigned CORDIC_ITERATIONS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    chc_in_if.sink      sample_in,
    chc_out_if.source   result_out,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    localparam int unsigned IW = $clog2(CORDIC_ITERATIONS);

    chc_pkg::cmd_t  cmd;
    chc_pkg::stat_t stat;
    chc_pkg::res_t  res;
    logic [IW-1:0]  step;

    chc_ctrl #(
        .CORDIC_ITERATIONS (CORDIC_ITERATIONS),
        .IW                (IW)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sample_in.valid),
        .in_ready  (sample_in.ready),
        .out_valid (result_out.valid),
        .out_ready (result_out.ready),
        .stat      (stat),
        .cmd       (cmd),
        .step      (step)
    );

    chc_datapath #(
        .CORDIC_ITERATIONS (CORDIC_ITERATIONS),
        .IW                (IW)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .command       (sample_in.command),
        .raw_x         (sample_in.raw_x),
        .raw_y         (sample_in.raw_y),
        .fresh         (sample_in.fresh),
        .load_offset_x (sample_in.load_offset_x),
        .load_offset_y (sample_in.load_offset_y),
        .load_scale_x  (sample_in.load_scale_x),
        .load_scale_y  (sample_in.load_scale_y),
        .cmd           (cmd),
        .step          (step),
        .stat          (stat),
        .res           (res)
    );

    // drive the result beat
    assign result_out.heading       = res.heading;
    assign result_out.heading_valid = res.heading_valid;
    assign result_out.cal_active    = res.cal_active;
    assign result_out.cal_count     = res.cal_count;
    assign result_out.cal_progress  = res.cal_progress;
    assign result_out.cal_good      = res.cal_good;
    assign result_out.stop_status   = res.stop_status;

`ifndef NO_ASSERTIONS
    a_head_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_out.valid |-> result_out.heading < chc_pkg::FULL_TURN)
        else $error("heading out of range");

    a_head_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_out.valid && !result_out.heading_valid) |-> result_out.heading == 15'd0)
        else $error("heading not cleared while invalid");

    a_progress: assert property (@(posedge clk) disable iff (!rst_n)
        result_out.valid |-> result_out.cal_progress <= 9'd256)
        else $error("progress above full");

    a_idle_progress: assert property (@(posedge clk) disable iff (!rst_n)
        (result_out.valid && !result_out.cal_active) |-> result_out.cal_progress == 9'd0)
        else $error("progress while calibration idle");

    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (sample_in.valid && sample_in.ready) |=> !sample_in.ready)
        else $error("second beat accepted while busy");
`endif

endmodule

### tb/sv/tb_chc_ifs.sv
// Testbench-side copies are not needed: the RTL interfaces chc_in_if and chc_out_if are used.
// This file holds a small helper package for the testbench; it depends on nothing.
`timescale 1ns / 1ps
package tb_chc_util;

    // one input beat as the predictor sees it
    typedef struct {
        logic [1:0]         command;
        logic signed [15:0] raw_x;
        logic signed [15:0] raw_y;
        logic               fresh;
        logic signed [15:0] load_offset_x;
        logic signed [15:0] load_offset_y;
        logic [15:0]        load_scale_x;
        logic [15:0]        load_scale_y;
    } beat_t;
endpackage

### tb/sv/tb_compass_heading_calibrator_top.sv
// Testbench for compass_heading_calibrator_top: directed and random beats, heading predictor.
// Depends on chc_pkg, tb_chc_util, chc_in_if, chc_out_if and the RTL.
`timescale 1ns / 1ps
module tb_compass_heading_calibrator_top;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [15:0] cfg_data;

    chc_in_if  sample_in ();
    chc_out_if result_out ();

    compass_heading_calibrator_top dut (
        .clk(clk), .rst_n(rst_n), .sample_in(sample_in), .result_out(result_out),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    localparam int TURN = 360 << 6;
    localparam int HALF = 180 << 6;

    // predictor state and configuration
    int unsigned p_decl, p_snap, p_mins, p_good, p_target, p_skip;
    int unsigned p_ema;
    bit          p_ema_ok, p_running;
    int unsigned p_count;
    int          p_min_x, p_max_x, p_min_y, p_max_y, p_off_x, p_off_y;
    longint      p_scale_x, p_scale_y;

    chc_pkg::res_t expected_q[$];
    int            mismatches;
    int            send_idle_pct;
    int            stall_pct;
    int            n_results;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #20ms;
        $display("** compass_heading_calibrator_top: FAILED **");
        $finish;
    end

    function automatic longint shr_floor(longint v, int s);
        return v >>> s;
    endfunction

    function automatic logic [31:0] atan_lut(int i);
        logic [31:0] t[16] = '{32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
            32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53,
            32'h00145F2F, 32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3,
            32'h0000A2FA, 32'h0000517D};
        return t[i];
    endfunction

    // vectoring rotation: angle of (x, y) in 2^32 units per turn
    function automatic logic [31:0] vector_angle(longint x, longint y);
        logic [31:0] z;
        longint      xs;
        longint      ys;
        z = 32'd0;
        if (x == 0 && y == 0)
            return 32'd0;
        if (x < 0)
        begin
            x = -x;
            y = -y;
            z = 32'h80000000;
        end
        for (int i = 0; i < 16; i++)
        begin
            xs = shr_floor(x, i);
            ys = shr_floor(y, i);
            if (y > 0)
            begin
                x += ys; y -= xs; z += atan_lut(i);
            end
            else
            begin
                x -= ys; y += xs; z -= atan_lut(i);
            end
        end
        return z;
    endfunction

    // run one sample through calibration tracking and the smoother
    task automatic heading_update(int rx, int ry);
        longint      dx;
        longint      dy;
        logic [63:0] wide;
        int          a;
        int          h;
        int          diff;
        int          e;
        if (p_running)
        begin
            if (p_count < 16'hFFFF)
                p_count++;
            if (p_count > p_skip)
            begin
                if (rx < p_min_x) p_min_x = rx;
                if (rx > p_max_x) p_max_x = rx;
                if (ry < p_min_y) p_min_y = ry;
                if (ry > p_max_y) p_max_y = ry;
            end
        end
        dx = longint'(rx) - p_off_x;
        dy = longint'(ry) - p_off_y;
        wide = 64'(vector_angle(-dy * p_scale_x, dx * p_scale_y)) * TURN + 64'h80000000;
        a = int'(wide >> 32);
        if (a >= TURN) a -= TURN;
        h = a + TURN - int'(p_decl % TURN);
        if (h >= TURN) h -= TURN;
        if (!p_ema_ok)
        begin
            p_ema = h;
            p_ema_ok = 1'b1;
            return;
        end
        diff = h - int'(p_ema);
        if (diff > HALF) diff -= TURN;
        if (diff < -HALF) diff += TURN;
        if ((diff < 0 ? -diff : diff) > int'(p_snap))
        begin
            p_ema = h;
            return;
        end
        e = int'(p_ema) + (diff >>> 1);
        if (e < 0) e += TURN;
        if (e >= TURN) e -= TURN;
        p_ema = e;
    endtask

    // apply one command beat and queue the status it must produce
    task automatic predict_status(tb_chc_util::beat_t b);
        chc_pkg::res_t r;
        logic [1:0]    st;
        int            sx;
        int            sy;
        int            weak_spr;
        longint        pr;
        st = chc_pkg::STOP_NONE;
        case (b.command)
            chc_pkg::CMD_SAMPLE:
                if (p_running || b.fresh || !p_ema_ok)
                    heading_update(b.raw_x, b.raw_y);
            chc_pkg::CMD_START:
            begin
                p_min_x = 32767; p_max_x = -32768;
                p_min_y = 32767; p_max_y = -32768;
                p_count = 0;
                p_running = 1'b1;
                p_ema_ok = 1'b0;
            end
            chc_pkg::CMD_STOP:
            begin
                p_running = 1'b0;
                if (p_count < p_mins)
                    st = chc_pkg::STOP_CANCEL;
                else
                begin
                    sx = p_max_x - p_min_x;
                    sy = p_max_y - p_min_y;
                    p_off_x = (p_min_x + p_max_x) / 2;
                    p_off_y = (p_min_y + p_max_y) / 2;
                    p_scale_x = sx > 1 ? sx : 2;
                    p_scale_y = sy > 1 ? sy : 2;
                    p_ema_ok = 1'b0;
                    st = chc_pkg::STOP_APPLIED;
                end
            end
            default:
            begin
                p_off_x = b.load_offset_x;
                p_off_y = b.load_offset_y;
                p_scale_x = b.load_scale_x == 0 ? 2 : b.load_scale_x;
                p_scale_y = b.load_scale_y == 0 ? 2 : b.load_scale_y;
                p_ema_ok = 1'b0;
            end
        endcase
        sx = p_max_x - p_min_x;
        sy = p_max_y - p_min_y;
        weak_spr = sx < sy ? sx : sy;
        r.cal_progress = 9'd0;
        if (p_running && p_count > p_skip && weak_spr > 0)
        begin
            pr = (longint'(weak_spr) << 8) / (p_target == 0 ? 1 : p_target);
            r.cal_progress = pr > 256 ? 9'd256 : 9'(pr);
        end
        r.heading = p_ema_ok ? 15'(p_ema) : 15'd0;
        r.heading_valid = p_ema_ok;
        r.cal_active = p_running;
        r.cal_count = 16'(p_count);
        r.cal_good = (p_count >= p_mins) && (weak_spr >= int'(p_good));
        r.stop_status = st;
        expected_q.push_back(r);
    endtask

    // send one beat, wait for its handshake, then drop valid
    task automatic send_beat(tb_chc_util::beat_t b);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
            @(posedge clk);
        sample_in.valid <= 1'b1;
        sample_in.command <= b.command;
        sample_in.raw_x <= b.raw_x;
        sample_in.raw_y <= b.raw_y;
        sample_in.fresh <= b.fresh;
        sample_in.load_offset_x <= b.load_offset_x;
        sample_in.load_offset_y <= b.load_offset_y;
        sample_in.load_scale_x <= b.load_scale_x;
        sample_in.load_scale_y <= b.load_scale_y;
        do
            @(posedge clk);
        while (!sample_in.ready);
        predict_status(b);
        sample_in.valid <= 1'b0;
        @(posedge clk);
    endtask

    // wait for all results, then let the block settle
    task automatic drain();
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [15:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        case (idx)
            chc_pkg::CFG_DECLINATION: p_decl = val[14:0];
            chc_pkg::CFG_SNAP:        p_snap = val[13:0];
            chc_pkg::CFG_MIN_SAMPLES: p_mins = val[9:0];
            chc_pkg::CFG_GOOD_SPREAD: p_good = val;
            chc_pkg::CFG_TARGET:      p_target = val;
            chc_pkg::CFG_SKIP:        p_skip = val[7:0];
            default:                  ;
        endcase
    endtask

    function automatic tb_chc_util::beat_t mk(logic [1:0] c, int x, int y, bit f);
        tb_chc_util::beat_t b;
        b.command = c;
        b.raw_x = 16'(x);
        b.raw_y = 16'(y);
        b.fresh = f;
        b.load_offset_x = 16'($urandom);
        b.load_offset_y = 16'($urandom);
        b.load_scale_x = 16'($urandom);
        b.load_scale_y = 16'($urandom);
        return b;
    endfunction

    function automatic tb_chc_util::beat_t rand_beat();
        return mk(2'($urandom), $urandom, $urandom, $urandom_range(1));
    endfunction

    // check each result beat against the oldest expectation
    initial
    begin
        chc_pkg::res_t e;
        mismatches = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && result_out.valid && result_out.ready)
            begin
                if (expected_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result beat at %0t", $time);
                end
                else
                begin
                    e = expected_q.pop_front();
                    n_results++;
                    if (result_out.heading !== e.heading
                        || result_out.heading_valid !== e.heading_valid
                        || result_out.cal_active !== e.cal_active
                        || result_out.cal_count !== e.cal_count
                        || result_out.cal_progress !== e.cal_progress
                        || result_out.cal_good !== e.cal_good
                        || result_out.stop_status !== e.stop_status)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"mismatch %0d: exp hdg %0d/%0b act %0d/%0b",
                                      " cal %0b/%0d/%0d/%0b/%0d act %0b/%0d/%0d/%0b/%0d"},
                                n_results, e.heading, e.heading_valid, result_out.heading,
                                result_out.heading_valid, e.cal_active, e.cal_count,
                                e.cal_progress, e.cal_good, e.stop_status,
                                result_out.cal_active, result_out.cal_count,
                                result_out.cal_progress, result_out.cal_good,
                                result_out.stop_status);
                    end
                end
            end
        end
    end

    // drive the receiver's ready with random stalls
    initial
    begin
        result_out.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            result_out.ready <= !(stall_pct != 0 && $urandom_range(99) < stall_pct);
        end
    end

    task automatic test_directed();
        tb_chc_util::beat_t b;
        send_beat(mk(chc_pkg::CMD_SAMPLE, 0, 0, 1));
        send_beat(mk(chc_pkg::CMD_SAMPLE, 1000, 0, 0));
        send_beat(mk(chc_pkg::CMD_SAMPLE, 1000, 0, 1));
        send_beat(mk(chc_pkg::CMD_SAMPLE, -32768, 32767, 1));
        send_beat(mk(chc_pkg::CMD_SAMPLE, 32767, -32768, 1));
        send_beat(mk(chc_pkg::CMD_SAMPLE, 0, -500, 1));
        send_beat(mk(chc_pkg::CMD_STOP, 0, 0, 0));
        send_beat(mk(chc_pkg::CMD_START, 0, 0, 0));
        send_beat(mk(chc_pkg::CMD_STOP, 0, 0, 0));
        send_beat(mk(chc_pkg::CMD_LOAD, 0, 0, 0));
        b = mk(chc_pkg::CMD_LOAD, 0, 0, 0);
        b.load_scale_x = 16'd0;
        b.load_scale_y = 16'hFFFF;
        b.load_offset_x = 16'sh8000;
        b.load_offset_y = 16'sh7FFF;
        send_beat(b);
        send_beat(mk(chc_pkg::CMD_SAMPLE, 0, 0, 0));
        send_beat(mk(chc_pkg::CMD_SAMPLE, -32768, -32768, 0));
    endtask

    // calibration rotations with random content, then stop and send eight samples after it
    task automatic test_calibration(int runs);
        int n;
        int cx;
        int cy;
        int rad;
        for (int r = 0; r < runs; r++)
        begin
            n = $urandom_range(90, 5);
            cx = $urandom_range(8000) - 4000;
            cy = $urandom_range(8000) - 4000;
            rad = $urandom_range(6000, 1);
            send_beat(mk(chc_pkg::CMD_START, 0, 0, 0));
            for (int i = 0; i < n; i++)
            begin
                if ($urandom_range(9) == 0)
                    send_beat(rand_beat());
                else
                    send_beat(mk(chc_pkg::CMD_SAMPLE, cx + $urandom_range(2 * rad) - rad,
                        cy + $urandom_range(2 * rad) - rad, $urandom_range(1)));
            end
            send_beat(mk(chc_pkg::CMD_STOP, 0, 0, 0));
            for (int i = 0; i < 8; i++)
                send_beat(mk(chc_pkg::CMD_SAMPLE, cx + $urandom_range(2 * rad) - rad,
                    cy + $urandom_range(2 * rad) - rad, $urandom_range(3) != 0));
        end
    endtask

    task automatic test_random(int count);
        for (int i = 0; i < count; i++)
            send_beat(rand_beat());
    endtask

    task automatic set_all(int d, int s, int m, int g, int t, int k);
        write_reg(chc_pkg::CFG_DECLINATION, 16'(d));
        write_reg(chc_pkg::CFG_SNAP, 16'(s));
        write_reg(chc_pkg::CFG_MIN_SAMPLES, 16'(m));
        write_reg(chc_pkg::CFG_GOOD_SPREAD, 16'(g));
        write_reg(chc_pkg::CFG_TARGET, 16'(t));
        write_reg(chc_pkg::CFG_SKIP, 16'(k));
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = 3'd0;
        cfg_data = 16'd0;
        sample_in.valid = 1'b0;
        sample_in.command = chc_pkg::CMD_SAMPLE;
        sample_in.raw_x = '0;
        sample_in.raw_y = '0;
        sample_in.fresh = 1'b0;
        sample_in.load_offset_x = '0;
        sample_in.load_offset_y = '0;
        sample_in.load_scale_x = '0;
        sample_in.load_scale_y = '0;
        send_idle_pct = 0;
        stall_pct = 0;
        n_results = 0;
        p_decl = chc_pkg::DECL_RST; p_snap = chc_pkg::SNAP_RST; p_mins = chc_pkg::MINS_RST;
        p_good = chc_pkg::GOOD_RST; p_target = chc_pkg::TARGET_RST;
        p_skip = chc_pkg::SKIP_RST;
        p_ema = 0; p_ema_ok = 0; p_running = 0; p_count = 0;
        p_min_x = 0; p_max_x = 0; p_min_y = 0; p_max_y = 0;
        p_off_x = 0; p_off_y = 0; p_scale_x = 2; p_scale_y = 2;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_calibration(2);
        drain();
        set_all(0, 0, 0, 0, 0, 0);
        send_idle_pct = 77;
        test_calibration(3);
        test_random(100);
        drain();
        set_all(32767, 16383, 1023, 65535, 65535, 255);
        stall_pct = 77;
        send_idle_pct = 0;
        test_calibration(2);
        test_random(80);
        drain();
        set_all(23039, 11520, 10, 100, 1, 2);
        send_idle_pct = 14;
        stall_pct = 14;
        test_calibration(4);
        test_random(80);
        drain();
        set_all($urandom_range(23039), $urandom_range(3000), 20, 2000, 3000, 3);
        send_idle_pct = 0;
        stall_pct = 0;
        test_calibration(3);
        test_random(60);
        drain();

        if (mismatches == 0 && expected_q.size() == 0)
            $display("** compass_heading_calibrator_top: PASSED **");
        else
            $display("** compass_heading_calibrator_top: FAILED **");
        $finish;
    end
endmodule
